@@ hdl/sie_pkg.sv @@
// shared constants and types for the set intersection engine
package sie_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int VALUE_W = 32;
  localparam int OPCODE_W = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int COUNT_MAX_OUT = 127;
  localparam int SAT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

  localparam int S_TDATA_W = 32;
  localparam int RES_W = VALUE_W + 1 + 1 + COUNT_OUT_W;
  localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int M_PAD_W = M_TDATA_W - RES_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_PROBE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the input request
    logic scan;    // read the next table entry
    logic commit;  // update table and load the result register
  } sie_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_scan;  // incoming request is an insert or a probe
    logic last_addr;   // scan address is at the last entry
    logic out_busy;    // result register full and not being taken
  } sie_stat_t;

endpackage

@@ hdl/sie_ctrl.sv @@
// sequencer for load, table scan and commit of one request
module sie_ctrl
  import sie_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  sie_stat_t stat,
  output sie_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = stat.needs_scan ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      // last read word is compared here
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/sie_datapath.sv @@
// entry memory, valid bits, scan compare, count and result register
module sie_datapath
  import sie_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [OPCODE_W-1:0]  s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  input  sie_cmd_t             cmd,
  output sie_stat_t            stat
);

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  op_t op_q;
  logic [VALUE_W-1:0] val_q;

  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic [VALUE_W-1:0] rd_data;
  logic cmp_en;

  logic hit_found;
  logic [IDX_W-1:0] hit_slot;
  logic free_found;
  logic [IDX_W-1:0] free_slot;

  logic cmp_valid;
  logic ins_ok;
  logic ins_full;
  logic prb_hit;
  logic is_clr;

  logic [SAT_W-1:0] count_ext;
  logic [COUNT_OUT_W-1:0] count_sat;

  logic out_valid;
  logic [VALUE_W-1:0] out_value;
  logic out_common;
  logic out_status;
  logic [COUNT_OUT_W-1:0] out_count;

  assign stat.needs_scan = (s_tuser == OP_INSERT) || (s_tuser == OP_PROBE);
  assign stat.last_addr = (rd_idx == IDX_W'(CAPACITY - 1));
  assign stat.out_busy = out_valid && !m_tready;

  // capture request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= op_t'(s_tuser);
      val_q <= s_tdata[VALUE_W-1:0];
    end
  end

  // scan address and registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.load) begin
        rd_idx <= '0;
      end else if (cmd.scan) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data <= mem[rd_idx];
      cmp_idx <= rd_idx;
    end
    if (cmd.commit && ins_ok) begin
      mem[free_slot] <= val_q;
    end
  end

  assign cmp_valid = valid[cmp_idx];

  // keep the first match and the lowest free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      hit_found <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_en) begin
      if (!hit_found && cmp_valid && (rd_data == val_q)) begin
        hit_found <= 1'b1;
      end
      if (!free_found && !cmp_valid) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en && !hit_found && cmp_valid && (rd_data == val_q)) begin
      hit_slot <= cmp_idx;
    end
    if (cmp_en && !free_found && !cmp_valid) begin
      free_slot <= cmp_idx;
    end
  end

  always_comb begin
    ins_ok = 1'b0;
    ins_full = 1'b0;
    prb_hit = 1'b0;
    is_clr = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        ins_ok = !hit_found && free_found;
        ins_full = !hit_found && !free_found;
      end
      OP_PROBE: begin
        prb_hit = hit_found;
      end
      OP_CLEAR: begin
        is_clr = 1'b1;
      end
      default: begin
        is_clr = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (is_clr) begin
      count_next = '0;
    end else if (ins_ok) begin
      count_next = count + 1'b1;
    end else if (prb_hit && (count != '0)) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
      if (is_clr) begin
        valid <= '0;
      end else if (ins_ok) begin
        valid[free_slot] <= 1'b1;
      end else if (prb_hit) begin
        valid[hit_slot] <= 1'b0;
      end
    end
  end

  // saturate the reported count to the field width
  assign count_ext = SAT_W'(count_next);
  assign count_sat = (count_ext > SAT_W'(COUNT_MAX_OUT)) ?
                     COUNT_OUT_W'(COUNT_MAX_OUT) : count_ext[COUNT_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_value <= is_clr ? '0 : val_q;
      out_common <= prb_hit;
      out_status <= ins_full;
      out_count <= count_sat;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {{M_PAD_W{1'b0}}, out_count, out_status, out_common, out_value};

endmodule

@@ hdl/set_intersection_engine.sv @@
// top level of the set intersection engine
// usage:
//   input stream s_*: s_tuser carries the opcode (insert first-list value, probe
//   second-list value, clear table); s_tdata carries the 32-bit value.
//   output stream m_*: one result per request, in request order.
//   insert and probe sweep the 64-entry value memory one entry per cycle through
//   its single read port before the commit; clear and unknown opcodes go straight
//   from acceptance to the commit.
//   one request is in flight at a time; s_tready is high while the engine waits.
//   the result register lets a new request start while the previous result is
//   still held; a request finishes only once that register is free, so a
//   stalled receiver holds m_tvalid and m_tdata and in turn stops the input.
//   reset (rst, synchronous, active high) empties the table and the count and
//   drops any pending result; no clearing pass is needed.
//   stored_count saturates at 127.
module set_intersection_engine
  import sie_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
  input  logic [OPCODE_W-1:0]  s_tuser,   // [1:0] opcode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // [31:0] value_out, [32] is_common,
                                          // [33] status, [40:34] stored_count
);

  sie_cmd_t cmd;
  sie_stat_t stat;

  sie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sie_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
